// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL. Every assertion samples on the rising
// edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Whenever the antecedent holds, the consequent must hold as written.
`define HEC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The expression must hold at every sampled edge.
`define HEC_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`else

`define HEC_ASSERT_IMPLY(label, ante, cons, msg)
`define HEC_ASSERT_ALWAYS(label, expr, msg)

`endif

`endif

// ===== sv/hec_pkg.sv =====
package hec_pkg;

   localparam int WORD_W          = 31;
   localparam int SYN_W           = 5;
   localparam int CSR_W           = 5;
   localparam int DATA_BITS_RESET = 4;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_CHECK  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [WORD_W-1:0] word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] code_word;
      logic [SYN_W-1:0]  syndrome;
      logic              error_found;
      logic              position_invalid;
   } rsp_type;

   // Smallest parity count r with 2^r >= m + r + 1.
   function automatic int parity_count(input int m);
      int r;
      r = 1;
      while (r < 16 && (1 << r) < m + r + 1) begin
         r++;
      end
      return r;
   endfunction

endpackage

// ===== sv/hec_cfg.sv =====
module hec_cfg
   import hec_pkg::*;
#(
   parameter  int MAX_DATA_BITS = 26,
   localparam int MAX_R         = parity_count(MAX_DATA_BITS),
   localparam int M_W           = $clog2(MAX_DATA_BITS + 1),
   localparam int N_W           = $clog2(MAX_DATA_BITS + MAX_R + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   output logic [M_W-1:0]   data_len,
   output logic [N_W-1:0]   code_len
);

   localparam int RST_M = (DATA_BITS_RESET > MAX_DATA_BITS) ? MAX_DATA_BITS : DATA_BITS_RESET;
   localparam int RST_N = RST_M + parity_count(RST_M);

   logic [M_W-1:0] data_len_ff, data_len_in;
   logic [N_W-1:0] code_len_ff, code_len_in;

   // The clamped data length and the matching code length are worked out at
   // the write, so the datapath only sees settled values.
   always_comb begin
      int mval;
      int rval;
      mval = int'(csr_wr_data);
      if (mval < 1) begin
         mval = 1;
      end else if (mval > MAX_DATA_BITS) begin
         mval = MAX_DATA_BITS;
      end
      rval = MAX_R;
      for (int j = MAX_R; j >= 1; j--) begin
         if ((1 << j) >= mval + j + 1) begin
            rval = j;
         end
      end
      data_len_in = M_W'(mval);
      code_len_in = N_W'(mval + rval);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_len_ff <= M_W'(RST_M);
         code_len_ff <= N_W'(RST_N);
      end else if (csr_wr_en) begin
         data_len_ff <= data_len_in;
         code_len_ff <= code_len_in;
      end
   end

   assign data_len = data_len_ff;
   assign code_len = code_len_ff;

endmodule

// ===== sv/hec_core.sv =====
module hec_core
   import hec_pkg::*;
#(
   parameter  int MAX_DATA_BITS = 26,
   localparam int MAX_R         = parity_count(MAX_DATA_BITS),
   localparam int MAX_N         = MAX_DATA_BITS + MAX_R,
   localparam int M_W           = $clog2(MAX_DATA_BITS + 1),
   localparam int N_W           = $clog2(MAX_N + 1)
) (
   input  req_type        req,
   input  logic [M_W-1:0] data_len,
   input  logic [N_W-1:0] code_len,
   output rsp_type        rsp
);

   logic [MAX_DATA_BITS-1:0] dvec;
   logic [MAX_N-1:0]         edat;
   logic [MAX_N-1:0]         enc_word;
   logic [MAX_N-1:0]         chk;
   logic [MAX_N-1:0]         sel;
   logic [MAX_N-1:0]         fixed;
   logic [MAX_N-1:0]         res;
   logic [MAX_R-1:0]         syn;
   logic                     is_check;
   logic                     err;
   logic                     beyond;
   logic                     flip;

   assign is_check = (req.cmd == CMD_CHECK);

   // Data bits above the configured length are dropped.
   for (genvar k = 0; k < MAX_DATA_BITS; k++) begin : g_data
      if (k < WORD_W) begin : g_in
         assign dvec[k] = req.word[k] & (int'(data_len) > k);
      end else begin : g_zero
         assign dvec[k] = 1'b0;
      end
   end

   // Position p (1-based) holds data bit p-2-floor(log2 p) unless p is a power
   // of two, where a parity bit goes. Received bits beyond the code are cleared.
   for (genvar p = 1; p <= MAX_N; p++) begin : g_pos
      if ((p & (p - 1)) == 0) begin : g_par
         assign edat[p-1]     = 1'b0;
         assign enc_word[p-1] = syn[$clog2(p)];
      end else begin : g_dat
         assign edat[p-1]     = dvec[p - 1 - $clog2(p + 1)];
         assign enc_word[p-1] = edat[p-1];
      end
      if (p - 1 < WORD_W) begin : g_rx
         assign chk[p-1] = req.word[p-1] & (int'(code_len) >= p);
      end else begin : g_rx0
         assign chk[p-1] = 1'b0;
      end
      assign fixed[p-1] = chk[p-1] ^ (flip && (syn == MAX_R'(p)));
   end

   assign sel = is_check ? chk : edat;

   // One XOR tree per parity check; it yields the parity bits when encoding
   // and the syndrome when checking.
   always_comb begin
      syn = '0;
      for (int i = 0; i < MAX_R; i++) begin
         for (int p = 1; p <= MAX_N; p++) begin
            if (((p >> i) & 1) == 1) begin
               syn[i] = syn[i] ^ sel[p-1];
            end
         end
      end
   end

   assign err    = is_check && (syn != '0);
   assign beyond = int'(syn) > int'(code_len);
   assign flip   = err && !beyond;
   assign res    = is_check ? fixed : enc_word;

   for (genvar b = 0; b < WORD_W; b++) begin : g_out
      if (b < MAX_N) begin : g_bit
         assign rsp.code_word[b] = res[b];
      end else begin : g_zero
         assign rsp.code_word[b] = 1'b0;
      end
   end

   for (genvar b = 0; b < SYN_W; b++) begin : g_syn
      if (b < MAX_R) begin : g_bit
         assign rsp.syndrome[b] = syn[b] & is_check;
      end else begin : g_zero
         assign rsp.syndrome[b] = 1'b0;
      end
   end

   assign rsp.error_found      = err;
   assign rsp.position_invalid = err && beyond;

endmodule

// ===== sv/hamming_encode_correct.sv =====
// Channel      Ports                                  Transfer rule
// request      start, busy, req_payload               start high and busy low at a clock edge
// response     rsp_valid, rsp_payload                 rsp_valid high for one cycle, always taken
// csr          csr_wr_en, csr_wr_data                 csr_wr_en high at a clock edge
//
// One transaction is accepted every cycle; busy is held low, as the pipeline
// never has to pause. A request passes through one input register, the parity
// XOR trees, then the response register before its response is on the ports.
// Reset is synchronous and active high; it clears the valid flags and sets
// the data length to four bits. The receiver cannot stall the response.
`include "assert_macros.svh"

module hamming_encode_correct
   import hec_pkg::*;
#(
   parameter int MAX_DATA_BITS = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int MAX_R = parity_count(MAX_DATA_BITS);
   localparam int M_W   = $clog2(MAX_DATA_BITS + 1);
   localparam int N_W   = $clog2(MAX_DATA_BITS + MAX_R + 1);

   logic           req_vld_ff, req_vld_in;
   req_type        req_ff;
   logic           rsp_vld_ff;
   rsp_type        rsp_ff, rsp_in;
   logic [M_W-1:0] data_len;
   logic [N_W-1:0] code_len;

   // The block keeps pace with any request stream, so it never pushes back.
   assign busy       = 1'b0;
   assign req_vld_in = start && !busy;

   // The configured length is held in clamped form along with the derived code length; the user
   // must make writes only while no transaction is in flight, which the block does not enforce.
   hec_cfg #(
      .MAX_DATA_BITS (MAX_DATA_BITS)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .data_len    (data_len),
      .code_len    (code_len)
   );

   // Request register. The payload needs no reset; only the valid flag does.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_in) begin
         req_ff <= req_payload;
      end
   end

   // Encoding and checking share one set of parity trees between the two
   // registers.
   hec_core #(
      .MAX_DATA_BITS (MAX_DATA_BITS)
   ) u_core (
      .req      (req_ff),
      .data_len (data_len),
      .code_len (code_len),
      .rsp      (rsp_in)
   );

   // Response register. Each result is shown for exactly one cycle, and a
   // new one may follow directly behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // Every accepted request must produce its response through the request and response registers.
   `HEC_ASSERT_IMPLY(a_latency, start && !busy, ##2 rsp_valid, "response missing after request")

   // A response strobe never appears without a request in the stage before.
   `HEC_ASSERT_IMPLY(a_no_phantom, rsp_valid, $past(req_vld_ff), "response without request")

   // A syndrome outside the code is always reported as an error as well.
   `HEC_ASSERT_IMPLY(a_invalid_err, rsp_valid && rsp_payload.position_invalid, rsp_payload.error_found, "invalid position without error flag")

endmodule

// ===== verif/hamming_encode_correct_tb.sv =====
`timescale 1ns / 1ps

module hamming_encode_correct_tb;
   import hec_pkg::*;

   localparam int MAX_DATA_BITS = 26;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 50;
   localparam int DRAIN_CYCLES  = 4;

   // One row of the directed table. When load_len is set, the data length
   // register is written (with the pipeline drained) before the transaction.
   // When known is set, the response is typed in and is not predicted.
   typedef struct {
      logic              load_len;
      logic [CSR_W-1:0]  len;
      cmd_type           cmd;
      logic [WORD_W-1:0] word;
      logic              known;
      logic [WORD_W-1:0] code;
      logic [SYN_W-1:0]  syn;
      logic              err;
      logic              inval;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_payload;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   // The testbench's own copy of the data length register.
   logic [CSR_W-1:0] data_len;
   // Responses still owed by the block, oldest first.
   rsp_type          pending_codes[$];
   int               error_count;
   int               cycle_count;
   // When set, the sender never inserts idle cycles.
   logic             back_to_back;

   hamming_encode_correct #(
      .MAX_DATA_BITS(MAX_DATA_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The directed table. Typed-in responses are the ones that can be worked
   // out by hand: zero words, all-ones words, single flips of those, and the
   // syndromes that point past the end of a short code.
   stim_row_type directed_rows[23] = '{
      // Data length four after reset: seven-bit code, three parity bits.
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h0000_0000, 1'b1, 31'h0000_0000, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h7FFF_FFFF, 1'b1, 31'h0000_007F, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h7FFF_FFFF, 1'b1, 31'h0000_007F, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h0000_007E, 1'b1, 31'h0000_007F, 5'd1,  1'b1, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h0000_0004, 1'b1, 31'h0000_0000, 5'd3,  1'b1, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h0000_003F, 1'b1, 31'h0000_007F, 5'd7,  1'b1, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h0000_0005, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0},
      // Five data bits give a nine-bit code, so syndromes 10 to 15 are invalid.
      '{1'b1, 5'd5,  CMD_CHECK,  31'h0000_0082, 1'b1, 31'h0000_0082, 5'd10, 1'b1, 1'b1},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h0000_0120, 1'b1, 31'h0000_0120, 5'd15, 1'b1, 1'b1},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h7FFF_FE00, 1'b1, 31'h0000_0000, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h0000_001F, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0},
      // A length of zero is treated as one data bit: a three-bit code.
      '{1'b1, 5'd0,  CMD_ENCODE, 31'h0000_0001, 1'b1, 31'h0000_0007, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h7FFF_FFFE, 1'b1, 31'h0000_0000, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h7FFF_FFFF, 1'b1, 31'h0000_0007, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h0000_0003, 1'b1, 31'h0000_0007, 5'd3,  1'b1, 1'b0},
      // A length above the maximum is clamped to 26: the full 31-bit code.
      '{1'b1, 5'd31, CMD_ENCODE, 31'h03FF_FFFF, 1'b1, 31'h7FFF_FFFF, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFF, 5'd1,  1'b1, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h3FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 5'd31, 1'b1, 1'b0},
      '{1'b0, 5'd0,  CMD_ENCODE, 31'h02AA_AAAA, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0},
      '{1'b0, 5'd0,  CMD_CHECK,  31'h1234_5678, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0},
      '{1'b1, 5'd26, CMD_ENCODE, 31'h0155_5555, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0},
      '{1'b1, 5'd1,  CMD_CHECK,  31'h0000_0005, 1'b0, 31'h0,         5'd0,  1'b0, 1'b0}
   };

   // Code length n = m + r for a given register value. The register is
   // clamped to 1..MAX_DATA_BITS first, and r is the smallest parity count
   // with 2^r >= m + r + 1.
   function automatic int code_length(input logic [CSR_W-1:0] len_reg);
      int m;
      int r;
      m = int'(len_reg);
      if (m < 1) m = 1;
      if (m > MAX_DATA_BITS) m = MAX_DATA_BITS;
      r = 1;
      while ((1 << r) < m + r + 1) r++;
      return m + r;
   endfunction

   // With even parity the syndrome is simply the XOR of the positions of all
   // set bits, since each parity check covers the positions with its bit set.
   function automatic logic [SYN_W-1:0] position_xor(input logic [WORD_W-1:0] bits,
                                                      input int n);
      logic [SYN_W-1:0] s;
      s = '0;
      for (int p = 1; p <= n; p++) begin
         if (bits[p-1]) s ^= SYN_W'(p);
      end
      return s;
   endfunction

   // Predicts the response to one transaction under the given data length.
   function automatic rsp_type hamming_encode_or_correct(input req_type item,
                                                          input logic [CSR_W-1:0] len_reg);
      rsp_type           res;
      int                n;
      int                k;
      logic [WORD_W-1:0] in_code;
      logic [SYN_W-1:0]  s;
      res = '0;
      n = code_length(len_reg);
      if (item.cmd == CMD_ENCODE) begin
         // Data bits go, lowest first, to the positions that are not powers
         // of two; each parity bit is then set where its check comes out odd.
         k = 0;
         for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               res.code_word[p-1] = item.word[k];
               k++;
            end
         end
         s = position_xor(res.code_word, n);
         for (int i = 0; i < SYN_W; i++) begin
            if (s[i]) res.code_word[(1 << i) - 1] = 1'b1;
         end
      end else begin
         in_code = (n >= WORD_W) ? item.word : (item.word & ((WORD_W'(1) << n) - 1));
         s = position_xor(in_code, n);
         res.code_word = in_code;
         res.syndrome  = s;
         if (s != 0) begin
            res.error_found = 1'b1;
            if (int'(s) > n) res.position_invalid = 1'b1;
            else res.code_word[s-1] = ~in_code[s-1];
         end
      end
      return res;
   endfunction

   // Idle cycles before the next transaction: none when back_to_back is set,
   // otherwise mostly none or a few, rarely a long stretch.
   function automatic int pick_gap();
      int roll;
      if (back_to_back) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offers one transaction and waits for the block to take it. The start
   // line stays high from one transaction to the next when no gap is picked,
   // so it is never lowered and raised within one time step.
   task automatic send_item(input req_type item, input rsp_type expected);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      pending_codes.push_back(expected);
   endtask

   // Stops sending, waits for every owed response, then lets the two-stage
   // pipeline empty out completely.
   task automatic drain();
      start <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the data length register with the block idle.
   task automatic load_length(input logic [CSR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      data_len = value;
   endtask

   // Builds one random transaction. Check transactions are mostly real code
   // words, clean or with one or two flipped bits, sometimes with junk above
   // the code length; the rest are random noise.
   task automatic build_random_item(output req_type item);
      int                n;
      int                sel;
      int                p1;
      int                p2;
      req_type           enc;
      rsp_type           enc_rsp;
      logic [WORD_W-1:0] cw;
      logic [WORD_W-1:0] high_mask;
      n = code_length(data_len);
      item.cmd  = cmd_type'($urandom_range(0, 1));
      item.word = WORD_W'($urandom());
      if (item.cmd == CMD_CHECK) begin
         sel = $urandom_range(0, 9);
         if (sel >= 2) begin
            enc.cmd  = CMD_ENCODE;
            enc.word = WORD_W'($urandom());
            enc_rsp  = hamming_encode_or_correct(enc, data_len);
            cw = enc_rsp.code_word;
            p1 = $urandom_range(1, n);
            if (sel >= 4) cw[p1-1] = ~cw[p1-1];
            if (sel == 9) begin
               p2 = $urandom_range(1, n);
               while (p2 == p1) p2 = $urandom_range(1, n);
               cw[p2-1] = ~cw[p2-1];
            end
            if (n < WORD_W && $urandom_range(0, 1) == 1) begin
               high_mask = ~((WORD_W'(1) << n) - 1);
               cw |= WORD_W'($urandom()) & high_mask;
            end
            item.word = cw;
         end
      end
   endtask

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: ends the run if it takes far longer than any correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hamming_encode_correct_tb failed");
         $finish;
      end
   end

   // Response checker. A response is valid for exactly one cycle and is
   // taken at the edge that ends it, so it is sampled at every rising edge
   // and compared field by field with the oldest owed response.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_codes.size() == 0) begin
            $error("unexpected response: code_word %h syndrome %0d",
                   rsp_payload.code_word, rsp_payload.syndrome);
            error_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_payload.code_word !== want.code_word) begin
               $error("code_word: expected %h, got %h", want.code_word,
                      rsp_payload.code_word);
               error_count++;
            end
            if (rsp_payload.syndrome !== want.syndrome) begin
               $error("syndrome: expected %0d, got %0d", want.syndrome,
                      rsp_payload.syndrome);
               error_count++;
            end
            if (rsp_payload.error_found !== want.error_found) begin
               $error("error_found: expected %b, got %b", want.error_found,
                      rsp_payload.error_found);
               error_count++;
            end
            if (rsp_payload.position_invalid !== want.position_invalid) begin
               $error("position_invalid: expected %b, got %b",
                      want.position_invalid, rsp_payload.position_invalid);
               error_count++;
            end
         end
      end
   end

   // Register values visited by the random phases: both clamp ends, the
   // edges of the legal range, lengths whose code leaves invalid syndromes
   // reachable, and a few picked at random.
   logic [CSR_W-1:0] phase_lengths[14] = '{
      5'd1, 5'd26, 5'd27, 5'd0, 5'd2, 5'd3, 5'd11, 5'd12, 5'd5, 5'd16,
      5'd20, 5'd31, 5'd4, 5'd9
   };

   initial begin
      stim_row_type row;
      req_type item;
      rsp_type want;

      error_count  = 0;
      cycle_count  = 0;
      back_to_back = 1'b0;
      data_len     = 5'(DATA_BITS_RESET);
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the table above, walked row by row.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.load_len) load_length(row.len);
         item.cmd  = row.cmd;
         item.word = row.word;
         if (row.known) begin
            want.code_word        = row.code;
            want.syndrome         = row.syn;
            want.error_found      = row.err;
            want.position_invalid = row.inval;
         end else begin
            want = hamming_encode_or_correct(item, data_len);
         end
         send_item(item, want);
      end

      // Random part: one phase per register value. Every fourth phase runs
      // without any idle cycles; every fifth phase, starting with the first, also pauses
      // halfway until all owed responses have come back.
      foreach (phase_lengths[ph]) begin
         if (ph >= 10) load_length(5'($urandom_range(0, 31)));
         load_length(phase_lengths[ph]);
         back_to_back = (ph % 4 == 3);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            if (ph % 5 == 0 && j == PHASE_ITEMS / 2) drain();
            build_random_item(item);
            send_item(item, hamming_encode_or_correct(item, data_len));
         end
      end

      // Wait out the last responses, plus a little margin to catch strays.
      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("hamming_encode_correct_tb passed");
      end else begin
         $display("hamming_encode_correct_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/hec_pkg.sv
sv/hec_cfg.sv
sv/hec_core.sv
sv/hamming_encode_correct.sv
verif/hamming_encode_correct_tb.sv
